// ===== design/cbcn_pkg.sv =====
package cbcn_pkg;

    // Region codes of the result.
    localparam logic [3:0] REGION_INSIDE = 4'd0;
    localparam logic [3:0] REGION_LEFT   = 4'd1;
    localparam logic [3:0] REGION_RIGHT  = 4'd2;
    localparam logic [3:0] REGION_ABOVE  = 4'd3;
    localparam logic [3:0] REGION_BELOW  = 4'd4;
    localparam logic [3:0] REGION_TL     = 4'd5;
    localparam logic [3:0] REGION_TR     = 4'd6;
    localparam logic [3:0] REGION_BL     = 4'd7;
    localparam logic [3:0] REGION_BR     = 4'd8;

    // One in Q1.14.
    localparam logic [14:0] UNIT_Q14 = 15'd16384;

    // Number of root cells and of divider cells in the chain.
    localparam int SQRT_CELLS = 32;
    localparam int DIV_CELLS  = 15;

    typedef struct packed {
        logic signed [31:0] ball_x;
        logic signed [31:0] ball_y;
        logic signed [31:0] box_left;
        logic signed [31:0] box_top;
        logic [30:0]        box_width;
        logic [30:0]        box_height;
    } t_in_req;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [31:0] corner_x;
        logic signed [31:0] corner_y;
        logic [3:0]         region;
        logic               degenerate;
    } t_out_res;

    // Per-item information that rides along the chain unchanged.
    typedef struct packed {
        logic [3:0]         region;
        logic signed [31:0] corner_x;
        logic signed [31:0] corner_y;
        logic signed [15:0] edge_nx;
        logic signed [15:0] edge_ny;
        logic               neg_x;
        logic               neg_y;
        logic               is_corner;
        logic               degen;
    } t_side;

    // Square root cell state.
    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bit_m;
        logic [31:0] ax;
        logic [31:0] ay;
        t_side       side;
    } t_sq;

    // Divider cell state.
    typedef struct packed {
        logic [46:0] rx;
        logic [46:0] ry;
        logic [46:0] dsh;
        logic [14:0] qx;
        logic [14:0] qy;
        t_side       side;
    } t_dv;

endpackage

// ===== design/circle_box_contact_normal_top.sv =====
// Circle versus box contact normal. Each request (ball centre and box, Q16.16) yields one
// result: region, reference corner and a Q1.14 unit normal. The block is a fixed pipeline
// of 52 stages: three front stages (classify, scale, square), a chain of 32 square root
// cells, one divider setup stage, 15 restoring divider cells and the output register. It
// takes one request per clock when the output is not held. The whole chain advances
// together; while a result waits to be taken, the chain and the input stand still.
module circle_box_contact_normal_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cbcn_pkg::t_in_req  i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cbcn_pkg::t_out_res o_out_res
);
    import cbcn_pkg::*;

    logic     w_en;
    logic     w_sq_v [0:SQRT_CELLS];
    t_sq      w_sq   [0:SQRT_CELLS];
    logic     w_dv_v [0:DIV_CELLS];
    t_dv      w_dv   [0:DIV_CELLS];
    t_dv      n_dv0;
    t_dv      r_dv0;
    logic     r_dv0_v;
    logic [31:0] w_len;
    logic [14:0] w_mag_x, w_mag_y;
    t_out_res n_out;
    t_out_res r_out;
    logic     r_out_valid;

    // The chain moves whenever the output register is free or being emptied.
    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    cbcn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_req   (i_in_req),
        .o_valid (w_sq_v[0]),
        .o_sq    (w_sq[0])
    );

    // Square root chain.
    for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
        cbcn_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_sq_v[g]),
            .i_sq    (w_sq[g]),
            .o_valid (w_sq_v[g+1]),
            .o_sq    (w_sq[g+1])
        );
    end

    // Divider setup: rounded numerators and the divisor aligned to the top quotient bit.
    always_comb begin
        w_len      = w_sq[SQRT_CELLS].res[31:0];
        n_dv0      = '0;
        n_dv0.rx   = {1'b0, w_sq[SQRT_CELLS].ax, 14'd0} + 47'(w_len[31:1]);
        n_dv0.ry   = {1'b0, w_sq[SQRT_CELLS].ay, 14'd0} + 47'(w_len[31:1]);
        n_dv0.dsh  = {1'b0, w_len, 14'd0};
        n_dv0.side = w_sq[SQRT_CELLS].side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv0_v <= 1'b0;
        end else if (w_en) begin
            r_dv0_v <= w_sq_v[SQRT_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv0 <= n_dv0;
        end
    end

    assign w_dv_v[0] = r_dv0_v;
    assign w_dv[0]   = r_dv0;

    // Divider chain.
    for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
        cbcn_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_dv_v[g]),
            .i_dv    (w_dv[g]),
            .o_valid (w_dv_v[g+1]),
            .o_dv    (w_dv[g+1])
        );
    end

    // Clamp, sign and pick the normal for the region.
    always_comb begin
        w_mag_x = w_dv[DIV_CELLS].qx[14] ? UNIT_Q14 : w_dv[DIV_CELLS].qx;
        w_mag_y = w_dv[DIV_CELLS].qy[14] ? UNIT_Q14 : w_dv[DIV_CELLS].qy;
        n_out            = '0;
        n_out.corner_x   = w_dv[DIV_CELLS].side.corner_x;
        n_out.corner_y   = w_dv[DIV_CELLS].side.corner_y;
        n_out.region     = w_dv[DIV_CELLS].side.region;
        n_out.degenerate = w_dv[DIV_CELLS].side.degen;
        if (!w_dv[DIV_CELLS].side.is_corner) begin
            n_out.normal_x = w_dv[DIV_CELLS].side.edge_nx;
            n_out.normal_y = w_dv[DIV_CELLS].side.edge_ny;
        end else if (!w_dv[DIV_CELLS].side.degen) begin
            n_out.normal_x = w_dv[DIV_CELLS].side.neg_x ? -$signed({1'b0, w_mag_x})
                                                        : $signed({1'b0, w_mag_x});
            n_out.normal_y = w_dv[DIV_CELLS].side.neg_y ? -$signed({1'b0, w_mag_y})
                                                        : $signed({1'b0, w_mag_y});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_dv_v[DIV_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    // Only corner regions can report a zero-length vector.
    a_degen_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_res.degenerate |->
            (o_out_res.region == REGION_TL || o_out_res.region == REGION_TR ||
             o_out_res.region == REGION_BL || o_out_res.region == REGION_BR))
        else $error("degenerate flag outside a corner region");

    // An inside result carries a zero normal and a zero corner.
    a_inside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_res.region == REGION_INSIDE |->
            o_out_res.normal_x == 16'sd0 && o_out_res.normal_y == 16'sd0 &&
            o_out_res.corner_x == 32'sd0 && o_out_res.corner_y == 32'sd0)
        else $error("inside result not zero");

    // The normal never exceeds one in magnitude.
    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            o_out_res.normal_x >= -16'sd16384 && o_out_res.normal_x <= 16'sd16384 &&
            o_out_res.normal_y >= -16'sd16384 && o_out_res.normal_y <= 16'sd16384)
        else $error("normal out of range");

    // A stalled output freezes the chain, so no request may be taken then.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("request taken while output stalled");

endmodule

// ===== design/cbcn_front.sv =====
module cbcn_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  cbcn_pkg::t_in_req i_req,
    output logic             o_valid,
    output cbcn_pkg::t_sq    o_sq
);
    import cbcn_pkg::*;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -34'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    logic               w_xmin, w_xmax, w_ymin, w_ymax;
    logic signed [33:0] w_bx, w_by, w_left, w_top, w_right, w_bottom;
    logic signed [33:0] w_cx, w_cy, w_dx, w_dy;
    t_side              n_side;
    logic [32:0]        n_ax, n_ay;

    logic               r_v1;
    t_side              r_side1;
    logic [32:0]        r_ax1, r_ay1;

    logic [32:0]        w_m;
    logic [30:0]        w_mm, w_sx, w_sy;
    logic [31:0]        n_nax, n_nay;

    logic               r_v2;
    t_side              r_side2;
    logic [31:0]        r_nax2, r_nay2;

    logic [63:0]        w_sqx, w_sqy;

    logic               r_v3;
    t_sq                r_sq3;
    t_sq                n_sq3;

    // Classification, reference corner and corner vector.
    always_comb begin
        w_bx     = 34'(i_req.ball_x);
        w_by     = 34'(i_req.ball_y);
        w_left   = 34'(i_req.box_left);
        w_top    = 34'(i_req.box_top);
        w_right  = w_left + $signed({3'b000, i_req.box_width});
        w_bottom = w_top + $signed({3'b000, i_req.box_height});
        w_xmin   = (w_bx <= w_left);
        w_xmax   = !w_xmin && (w_bx >= w_right);
        w_ymin   = (w_by <= w_top);
        w_ymax   = !w_ymin && (w_by >= w_bottom);
        w_cx     = w_xmin ? w_left : w_right;
        w_cy     = w_ymin ? w_top : w_bottom;
        w_dx     = w_cx - w_bx;
        w_dy     = w_cy - w_by;
        n_ax     = w_dx[33] ? 33'(-w_dx) : w_dx[32:0];
        n_ay     = w_dy[33] ? 33'(-w_dy) : w_dy[32:0];

        n_side           = '0;
        n_side.neg_x     = w_xmax;
        n_side.neg_y     = w_ymax;
        if ((w_xmin || w_xmax) && !(w_ymin || w_ymax)) begin
            n_side.corner_y = sat32(w_top);
            if (w_xmin) begin
                n_side.region   = REGION_LEFT;
                n_side.corner_x = sat32(w_left);
                n_side.edge_nx  = 16'sd16384;
            end else begin
                n_side.region   = REGION_RIGHT;
                n_side.corner_x = sat32(w_right);
                n_side.edge_nx  = -16'sd16384;
            end
        end else if (!(w_xmin || w_xmax) && (w_ymin || w_ymax)) begin
            n_side.corner_x = sat32(w_left);
            if (w_ymin) begin
                n_side.region   = REGION_ABOVE;
                n_side.corner_y = sat32(w_top);
                n_side.edge_ny  = 16'sd16384;
            end else begin
                n_side.region   = REGION_BELOW;
                n_side.corner_y = sat32(w_bottom);
                n_side.edge_ny  = -16'sd16384;
            end
        end else if (!(w_xmin || w_xmax)) begin
            n_side.region = REGION_INSIDE;
        end else begin
            n_side.corner_x  = sat32(w_cx);
            n_side.corner_y  = sat32(w_cy);
            n_side.is_corner = 1'b1;
            n_side.degen     = (n_ax == '0) && (n_ay == '0);
            if (w_ymin) begin
                n_side.region = w_xmin ? REGION_TL : REGION_TR;
            end else begin
                n_side.region = w_xmin ? REGION_BL : REGION_BR;
            end
        end
    end

    // Scale both magnitudes so the larger lies in [2^30, 2^31).
    always_comb begin
        w_m  = (r_ax1 > r_ay1) ? r_ax1 : r_ay1;
        w_mm = w_m[30:0];
        w_sx = r_ax1[30:0];
        w_sy = r_ay1[30:0];
        for (int k = 4; k >= 0; k--) begin
            if ((w_mm >> (31 - (1 << k))) == '0) begin
                w_mm = w_mm << (1 << k);
                w_sx = w_sx << (1 << k);
                w_sy = w_sy << (1 << k);
            end
        end
        if (w_m[32] || w_m[31]) begin
            n_nax = r_ax1[32:1];
            n_nay = r_ay1[32:1];
        end else begin
            n_nax = {1'b0, w_sx};
            n_nay = {1'b0, w_sy};
        end
    end

    // Sum of squares, kept to 64 bits, seeds the root chain.
    always_comb begin
        w_sqx       = r_nax2 * r_nax2;
        w_sqy       = r_nay2 * r_nay2;
        n_sq3       = '0;
        n_sq3.rem   = w_sqx + w_sqy;
        n_sq3.bit_m = 64'h4000_0000_0000_0000;
        n_sq3.ax    = r_nax2;
        n_sq3.ay    = r_nay2;
        n_sq3.side  = r_side2;
    end

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side1 <= n_side;
            r_ax1   <= n_ax;
            r_ay1   <= n_ay;
            r_side2 <= r_side1;
            r_nax2  <= n_nax;
            r_nay2  <= n_nay;
            r_sq3   <= n_sq3;
        end
    end

    assign o_valid = r_v3;
    assign o_sq    = r_sq3;

endmodule

// ===== design/cbcn_sqrt_cell.sv =====
module cbcn_sqrt_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  cbcn_pkg::t_sq i_sq,
    output logic          o_valid,
    output cbcn_pkg::t_sq o_sq
);
    import cbcn_pkg::*;

    logic [63:0] w_trial;
    t_sq         n_sq;
    t_sq         r_sq;
    logic        r_valid;

    // One result bit of the integer square root.
    always_comb begin
        n_sq    = i_sq;
        w_trial = i_sq.res + i_sq.bit_m;
        if (i_sq.rem >= w_trial) begin
            n_sq.rem = i_sq.rem - w_trial;
            n_sq.res = (i_sq.res >> 1) + i_sq.bit_m;
        end else begin
            n_sq.res = i_sq.res >> 1;
        end
        n_sq.bit_m = i_sq.bit_m >> 2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= n_sq;
        end
    end

    assign o_valid = r_valid;
    assign o_sq    = r_sq;

endmodule

// ===== design/cbcn_div_cell.sv =====
module cbcn_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  cbcn_pkg::t_dv i_dv,
    output logic          o_valid,
    output cbcn_pkg::t_dv o_dv
);
    import cbcn_pkg::*;

    t_dv  n_dv;
    t_dv  r_dv;
    logic r_valid;

    // One restoring quotient bit for both components.
    always_comb begin
        n_dv = i_dv;
        if (i_dv.rx >= i_dv.dsh) begin
            n_dv.rx = i_dv.rx - i_dv.dsh;
            n_dv.qx = {i_dv.qx[13:0], 1'b1};
        end else begin
            n_dv.qx = {i_dv.qx[13:0], 1'b0};
        end
        if (i_dv.ry >= i_dv.dsh) begin
            n_dv.ry = i_dv.ry - i_dv.dsh;
            n_dv.qy = {i_dv.qy[13:0], 1'b1};
        end else begin
            n_dv.qy = {i_dv.qy[13:0], 1'b0};
        end
        n_dv.dsh = i_dv.dsh >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv <= n_dv;
        end
    end

    assign o_valid = r_valid;
    assign o_dv    = r_dv;

endmodule

// ===== sim/circle_box_contact_normal_top_test.sv =====
`timescale 1ns / 100ps

module circle_box_contact_normal_top_test;
    import cbcn_pkg::*;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_ready;
    t_in_req  i_in_req;
    logic     o_out_valid;
    logic     i_out_ready;
    t_out_res o_out_res;

    t_out_res expected_normals[$];
    int       n_errors;
    int       send_idle_pct;
    int       recv_idle_pct;

    circle_box_contact_normal_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_req   (i_in_req),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_res  (o_out_res)
    );

    // Clock generation.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Integer square root, bit by bit.
    function automatic logic [63:0] root_floor(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = 64'd0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // Expected result for one ball-box request.
    function automatic t_out_res contact_normal(input t_in_req r);
        t_out_res o;
        logic signed [63:0] bx, by, lft, tp, rgt, btm, cx, cy, dx, dy;
        logic [63:0] ax, ay, m, len, qx, qy;
        logic xmin, xmax, ymin, ymax;
        bx = r.ball_x;
        by = r.ball_y;
        lft = r.box_left;
        tp = r.box_top;
        rgt = lft + $signed({33'd0, r.box_width});
        btm = tp + $signed({33'd0, r.box_height});
        xmin = bx <= lft;
        xmax = !xmin && bx >= rgt;
        ymin = by <= tp;
        ymax = !ymin && by >= btm;
        o = '0;
        cx = 0;
        cy = 0;
        if ((xmin || xmax) && !(ymin || ymax)) begin
            cy = tp;
            cx = xmin ? lft : rgt;
            o.region = xmin ? REGION_LEFT : REGION_RIGHT;
            o.normal_x = xmin ? 16'sd16384 : -16'sd16384;
        end else if (!(xmin || xmax) && (ymin || ymax)) begin
            cx = lft;
            cy = ymin ? tp : btm;
            o.region = ymin ? REGION_ABOVE : REGION_BELOW;
            o.normal_y = ymin ? 16'sd16384 : -16'sd16384;
        end else if (!(xmin || xmax)) begin
            o.region = REGION_INSIDE;
        end else begin
            cx = xmin ? lft : rgt;
            cy = ymin ? tp : btm;
            o.region = ymin ? (xmin ? REGION_TL : REGION_TR) : (xmin ? REGION_BL : REGION_BR);
            dx = cx - bx;
            dy = cy - by;
            ax = dx < 0 ? -dx : dx;
            ay = dy < 0 ? -dy : dy;
            m = ax > ay ? ax : ay;
            if (m == 0) begin
                o.degenerate = 1'b1;
            end else begin
                // Normalize so the larger magnitude sits in [2^30, 2^31).
                if (m >= 64'd1 << 31) begin
                    ax = ax >> 1;
                    ay = ay >> 1;
                end else begin
                    while (m < 64'd1 << 30) begin
                        m = m << 1;
                        ax = ax << 1;
                        ay = ay << 1;
                    end
                end
                len = root_floor(ax * ax + ay * ay);
                qx = (ax * 16384 + len / 2) / len;
                qy = (ay * 16384 + len / 2) / len;
                if (qx > 16384) qx = 16384;
                if (qy > 16384) qy = 16384;
                o.normal_x = dx < 0 ? -$signed(qx[15:0]) : $signed(qx[15:0]);
                o.normal_y = dy < 0 ? -$signed(qy[15:0]) : $signed(qy[15:0]);
            end
        end
        o.corner_x = clamp32(cx);
        o.corner_y = clamp32(cy);
        return o;
    endfunction

    // Send one request and record its expected result.
    task automatic send_box(input t_in_req r);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req <= r;
        expected_normals.push_back(contact_normal(r));
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic send_parts(input logic [31:0] bx, input logic [31:0] by,
                              input logic [31:0] l, input logic [31:0] t,
                              input logic [30:0] w, input logic [30:0] h);
        t_in_req r;
        r.ball_x = bx;
        r.ball_y = by;
        r.box_left = l;
        r.box_top = t;
        r.box_width = w;
        r.box_height = h;
        send_box(r);
    endtask

    // Receiver stall and result check.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_normals.size() == 0) begin
                    $error("result with nothing expected");
                    n_errors++;
                end else begin
                    t_out_res e;
                    e = expected_normals.pop_front();
                    if (o_out_res.normal_x !== e.normal_x) begin
                        $error("normal_x exp %0d got %0d", e.normal_x, o_out_res.normal_x);
                        n_errors++;
                    end
                    if (o_out_res.normal_y !== e.normal_y) begin
                        $error("normal_y exp %0d got %0d", e.normal_y, o_out_res.normal_y);
                        n_errors++;
                    end
                    if (o_out_res.corner_x !== e.corner_x) begin
                        $error("corner_x exp %0d got %0d", e.corner_x, o_out_res.corner_x);
                        n_errors++;
                    end
                    if (o_out_res.corner_y !== e.corner_y) begin
                        $error("corner_y exp %0d got %0d", e.corner_y, o_out_res.corner_y);
                        n_errors++;
                    end
                    if (o_out_res.region !== e.region) begin
                        $error("region exp %0d got %0d", e.region, o_out_res.region);
                        n_errors++;
                    end
                    if (o_out_res.degenerate !== e.degenerate) begin
                        $error("degenerate exp %0d got %0d", e.degenerate,
                               o_out_res.degenerate);
                        n_errors++;
                    end
                end
            end
            i_out_ready <= !(recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
        end
    end

    // Every region, corners hit exactly, and extreme field values.
    task automatic test_directed();
        logic [31:0] L, T;
        L = 32'h0001_0000;
        T = 32'h0002_0000;
        send_parts(32'h0001_8000, 32'h0002_8000, L, T, 31'h0002_0000, 31'h0002_0000);
        send_parts(32'h0000_0000, 32'h0002_8000, L, T, 31'h0002_0000, 31'h0002_0000);
        send_parts(32'h0004_0000, 32'h0002_8000, L, T, 31'h0002_0000, 31'h0002_0000);
        send_parts(32'h0001_8000, 32'h0000_0000, L, T, 31'h0002_0000, 31'h0002_0000);
        send_parts(32'h0001_8000, 32'h0008_0000, L, T, 31'h0002_0000, 31'h0002_0000);
        send_parts(32'h0000_0000, 32'h0000_0000, L, T, 31'h0002_0000, 31'h0002_0000);
        send_parts(32'h0005_0000, 32'h0000_0000, L, T, 31'h0002_0000, 31'h0002_0000);
        send_parts(32'h0000_0000, 32'h0009_0000, L, T, 31'h0002_0000, 31'h0002_0000);
        send_parts(32'h0005_0000, 32'h0009_0000, L, T, 31'h0002_0000, 31'h0002_0000);
        // Ball exactly on the top-left and the bottom-right corner.
        send_parts(L, T, L, T, 31'h0002_0000, 31'h0002_0000);
        send_parts(32'h0003_0000, 32'h0004_0000, L, T, 31'h0002_0000, 31'h0002_0000);
        // Zero-size box, ball on it.
        send_parts(L, T, L, T, 31'd0, 31'd0);
        // Extremes: saturated corners and the longest vectors.
        send_parts(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                   31'h7fff_ffff, 31'h7fff_ffff);
        send_parts(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                   31'h7fff_ffff, 31'h7fff_ffff);
        send_parts(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                   31'h7fff_ffff, 31'h7fff_ffff);
        send_parts(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000,
                   31'h7fff_ffff, 31'h0);
        send_parts(32'h0000_0001, 32'h0000_0000, 32'h0, 32'h0, 31'h0, 31'h0);
        send_parts(32'hffff_ffff, 32'h0000_0001, 32'h0, 32'h0, 31'h1, 31'h1);
        send_parts(32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h8000_0000,
                   31'h7fff_ffff, 31'h7fff_ffff);
        send_parts(32'h7fff_ffff, 32'h0000_0000, 32'h0, 32'h0, 31'h0, 31'h0);
    endtask

    // Random requests: half in small neighborhoods so every region is hit, some on a box corner, some full range.
    task automatic test_random(input int count);
        t_in_req r;
        logic [31:0] l, t;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(3, 0))
                0: begin
                    r.ball_x = $urandom();
                    r.ball_y = $urandom();
                    r.box_left = $urandom();
                    r.box_top = $urandom();
                    r.box_width = $urandom();
                    r.box_height = $urandom();
                end
                1: begin
                    // Ball sitting exactly on a box corner.
                    l = $urandom();
                    t = $urandom();
                    r.box_left = l;
                    r.box_top = t;
                    r.box_width = $urandom_range(1 << 20, 0);
                    r.box_height = $urandom_range(1 << 20, 0);
                    r.ball_x = $urandom_range(1, 0) ? l : l + r.box_width;
                    r.ball_y = $urandom_range(1, 0) ? t : t + r.box_height;
                end
                default: begin
                    l = $signed($urandom_range(1 << 22, 0)) - (1 << 21);
                    t = $signed($urandom_range(1 << 22, 0)) - (1 << 21);
                    r.box_left = l;
                    r.box_top = t;
                    r.box_width = $urandom_range(1 << 21, 0);
                    r.box_height = $urandom_range(1 << 21, 0);
                    r.ball_x = $signed($urandom_range(1 << 24, 0)) - (1 << 23);
                    r.ball_y = $signed($urandom_range(1 << 24, 0)) - (1 << 23);
                end
            endcase
            send_box(r);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_normals.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    initial begin
        n_errors = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_req = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 22;
        recv_idle_pct = 58;
        test_directed();
        test_random(260);
        send_idle_pct = 58;
        recv_idle_pct = 22;
        test_random(260);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(260);
        drain_results();

        if (n_errors == 0) begin
            $display("circle_box_contact_normal_top: match");
        end else begin
            $display("circle_box_contact_normal_top: mismatch");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #2000000;
        $display("circle_box_contact_normal_top: mismatch");
        $finish;
    end

endmodule
